/* design/rwsg_pkg.sv */
`default_nettype none
package rwsg_pkg;

	localparam int MAX_SENDERS = 8;
	localparam int WINDOW_LEN  = 10;
	localparam int GRAY_DEPTH  = 16;

	localparam int SLOT_W  = $clog2(MAX_SENDERS);
	localparam int TCNT_W  = $clog2(MAX_SENDERS + 1);
	localparam int WIN_W   = $clog2(WINDOW_LEN);
	localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
	localparam int ADDR_W  = $clog2(MAX_SENDERS * WINDOW_LEN);
	localparam int GIDX_W  = $clog2(GRAY_DEPTH);
	localparam int GCNT_W  = $clog2(GRAY_DEPTH + 1);

	localparam int SUM_W   = 12;
	localparam int SQ_W    = 20;
	localparam int ROOT_W  = 17;
	localparam int SQRT_STEPS = 8;

	// Division by the window length: multiply by a rounded-up reciprocal, then shift.
	localparam int RECIP_SHIFT = 23;
	localparam int RECIP_W     = 20;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;

	localparam logic [2:0] MODE_REG  = 3'd0;
	localparam logic [2:0] MODE_PUSH = 3'd1;
	localparam logic [2:0] MODE_POP  = 3'd2;
	localparam logic [2:0] MODE_EVAL = 3'd3;
	localparam logic [2:0] MODE_CLR  = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_UNKNOWN  = 3'd1;
	localparam logic [2:0] ST_WINEDGE  = 3'd2;
	localparam logic [2:0] ST_TFULL    = 3'd3;
	localparam logic [2:0] ST_ALREADY  = 3'd4;

	typedef struct packed {
		logic                latch_in;
		logic                exec;
		logic                emit_final;
		logic                ev_clear;
		logic                rd_eval;
		logic                acc_sum;
		logic                mean_calc;
		logic                acc_sq;
		logic                var_calc;
		logic                sqrt_step;
		logic                k_calc;
		logic                append;
		logic                emit_grp;
		logic [TCNT_W-1:0]   slot;
		logic [CNT_W-1:0]    step;
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0]             mode;
		logic                   out_free;
		logic [MAX_SENDERS-1:0] test;
		logic                   grp_new;
	} dp_sts_t;

	function automatic logic [WIN_W-1:0] win_wrap(input logic [WIN_W:0] x);
		if (x >= (WIN_W+1)'(WINDOW_LEN)) begin
			return WIN_W'(x - (WIN_W+1)'(WINDOW_LEN));
		end
		return WIN_W'(x);
	endfunction

	function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
		return ADDR_W'(ADDR_W'(s) * ADDR_W'(WINDOW_LEN));
	endfunction

endpackage
`default_nettype wire

/* design/rwsg_ram.sv */
`default_nettype none
module rwsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 80
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* design/rwsg_datapath.sv */
`default_nettype none
module rwsg_datapath import rwsg_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctl_cmd_t          cmd,
	output dp_sts_t                sts,
	input  wire logic [2:0]        mode,
	input  wire logic [7:0]        sender_id,
	input  wire logic signed [7:0] rssi_sample,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [7:0]        cfg_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             status,
	output logic signed [7:0]      popped_rssi,
	output logic                   window_full,
	output logic                   group_valid,
	output logic [MAX_SENDERS-1:0] group_mask,
	output logic                   gray_nonempty,
	output logic                   last
);

	logic [2:0]             mode_q;
	logic [7:0]             id_q;
	logic [7:0]             rssi_q;
	logic [MAX_SENDERS-1:0] used_q;
	logic [7:0]             sender_q [MAX_SENDERS];
	logic [CNT_W-1:0]       fill_q   [MAX_SENDERS];
	logic [WIN_W-1:0]       head_q   [MAX_SENDERS];
	logic [7:0]             spread_q;
	logic [MAX_SENDERS-1:0] gray_q   [GRAY_DEPTH];
	logic [GCNT_W-1:0]      gray_cnt_q;

	logic [2:0]             res_status_q;
	logic                   res_full_q;
	logic                   res_pop_q;
	logic [MAX_SENDERS-1:0] res_mask_q;

	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sq_q;
	logic signed [7:0]       mean_q;
	logic [ROOT_W-1:0]       rem_q;
	logic [ROOT_W-1:0]       root_q;
	logic signed [7:0]       mean_arr_q [MAX_SENDERS];
	logic signed [13:0]      lo_q       [MAX_SENDERS];
	logic signed [13:0]      hi_q       [MAX_SENDERS];

	logic                    hit_any, free_any;
	logic [SLOT_W-1:0]       hit_idx, free_idx;
	logic [CNT_W-1:0]        hit_fill;
	logic [WIN_W-1:0]        hit_head;
	logic                    push_ok, pop_ok;
	logic [2:0]              st_c;
	logic                    full_c;

	logic                    ram_we, ram_re;
	logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
	logic [7:0]              ram_rdata;
	logic [SLOT_W-1:0]       ev_slot;

	logic [SUM_W-1:0]            sum_abs;
	logic [SUM_W+RECIP_W-1:0]    mean_prod;
	logic [7:0]                  mean_mag;
	logic signed [8:0]           diff;
	logic [7:0]                  diff_abs;
	logic [15:0]                 diff_sq;
	logic [SQ_W+RECIP_W-1:0]     var_prod;
	logic [ROOT_W-1:0]           sq_bit, sq_trial;
	logic [15:0]                 k_prod;
	logic [11:0]                 k_val;

	logic [MAX_SENDERS-1:0]  test_c, match_c, gmask_c;
	logic                    dup_c;

	assign ev_slot = cmd.slot[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			mode_q <= mode;
			id_q   <= sender_id;
			rssi_q <= rssi_sample;
		end
	end

	// Sender lookup and lowest free slot; scan downward so the lowest index wins.
	always_comb begin
		hit_any  = 1'b0;
		hit_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int s = MAX_SENDERS - 1; s >= 0; s--) begin
			if (used_q[s] && sender_q[s] == id_q) begin
				hit_any = 1'b1;
				hit_idx = SLOT_W'(s);
			end
			if (!used_q[s]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(s);
			end
		end
	end

	assign hit_fill = fill_q[hit_idx];
	assign hit_head = head_q[hit_idx];
	assign push_ok  = cmd.exec && mode_q == MODE_PUSH && hit_any
		&& hit_fill != CNT_W'(WINDOW_LEN);
	assign pop_ok   = cmd.exec && mode_q == MODE_POP && hit_any && hit_fill != '0;

	always_comb begin
		st_c   = ST_OK;
		full_c = 1'b0;
		case (mode_q)
			MODE_REG: begin
				if (hit_any) begin
					st_c = ST_ALREADY;
				end else if (!free_any) begin
					st_c = ST_TFULL;
				end
			end
			MODE_PUSH: begin
				if (!hit_any) begin
					st_c = ST_UNKNOWN;
				end else if (hit_fill == CNT_W'(WINDOW_LEN)) begin
					st_c   = ST_WINEDGE;
					full_c = 1'b1;
				end else begin
					full_c = (hit_fill + CNT_W'(1)) == CNT_W'(WINDOW_LEN);
				end
			end
			MODE_POP: begin
				if (!hit_any) begin
					st_c = ST_UNKNOWN;
				end else if (hit_fill == '0) begin
					st_c = ST_WINEDGE;
				end
			end
			default: begin
				st_c = ST_OK;
			end
		endcase
	end

	assign ram_we    = push_ok;
	assign ram_waddr = slot_base(hit_idx)
		+ ADDR_W'(win_wrap((WIN_W+1)'(hit_head) + (WIN_W+1)'(hit_fill)));
	assign ram_re    = pop_ok || cmd.rd_eval;
	assign ram_raddr = cmd.rd_eval
		? slot_base(ev_slot)
			+ ADDR_W'(win_wrap((WIN_W+1)'(head_q[ev_slot]) + (WIN_W+1)'(cmd.step)))
		: slot_base(hit_idx) + ADDR_W'(hit_head);

	rwsg_ram #(
		.WIDTH(8),
		.DEPTH(MAX_SENDERS * WINDOW_LEN)
	) u_samples (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rssi_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Window statistics arithmetic
	always_comb begin
		sum_abs   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		mean_prod = (SUM_W+RECIP_W)'(sum_abs) * (SUM_W+RECIP_W)'(RECIP);
		mean_mag  = mean_prod[RECIP_SHIFT +: 8];
		diff      = $signed({ram_rdata[7], ram_rdata}) - $signed({mean_q[7], mean_q});
		diff_abs  = diff[8] ? 8'(-diff) : 8'(diff);
		diff_sq   = 16'(diff_abs) * 16'(diff_abs);
		var_prod  = (SQ_W+RECIP_W)'(sq_q) * (SQ_W+RECIP_W)'(RECIP);
		sq_bit    = ROOT_W'(1) << (5'd14 - {1'b0, cmd.step[2:0], 1'b0});
		sq_trial  = root_q + sq_bit;
		k_prod    = 16'(spread_q) * 16'(root_q[7:0]);
		k_val     = k_prod[15:4];
	end

	always_ff @(posedge clk) begin
		if (cmd.ev_clear) begin
			sum_q <= '0;
			sq_q  <= '0;
		end
		if (cmd.acc_sum) begin
			sum_q <= sum_q + $signed({{(SUM_W-8){ram_rdata[7]}}, ram_rdata});
		end
		if (cmd.mean_calc) begin
			mean_q <= sum_q[SUM_W-1] ? $signed(8'(-mean_mag)) : $signed(mean_mag);
		end
		if (cmd.acc_sq) begin
			sq_q <= sq_q + SQ_W'(diff_sq);
		end
		if (cmd.var_calc) begin
			rem_q  <= ROOT_W'(var_prod >> RECIP_SHIFT);
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			if (rem_q >= sq_trial) begin
				rem_q  <= rem_q - sq_trial;
				root_q <= (root_q >> 1) + sq_bit;
			end else begin
				root_q <= root_q >> 1;
			end
		end
		if (cmd.k_calc) begin
			mean_arr_q[ev_slot] <= mean_q;
			lo_q[ev_slot] <= 14'(mean_q) - $signed({2'b00, k_val});
			hi_q[ev_slot] <= 14'(mean_q) + $signed({2'b00, k_val});
		end
	end

	// Similarity test of the slot under evaluation against all other slots with a full window
	always_comb begin
		for (int u = 0; u < MAX_SENDERS; u++) begin
			test_c[u]  = used_q[u] && fill_q[u] == CNT_W'(WINDOW_LEN);
		end
		for (int u = 0; u < MAX_SENDERS; u++) begin
			match_c[u] = SLOT_W'(u) != ev_slot && test_c[u]
				&& 14'(mean_arr_q[u]) > lo_q[ev_slot]
				&& 14'(mean_arr_q[u]) < hi_q[ev_slot];
		end
		gmask_c = match_c | (MAX_SENDERS'(1) << ev_slot);
		dup_c   = 1'b0;
		for (int g = 0; g < GRAY_DEPTH; g++) begin
			if (GCNT_W'(g) < gray_cnt_q && gray_q[g] == gmask_c) begin
				dup_c = 1'b1;
			end
		end
	end

	assign sts.mode     = mode_q;
	assign sts.out_free = !out_valid || out_ready;
	assign sts.test     = test_c;
	assign sts.grp_new  = test_c[ev_slot] && (|match_c) && !dup_c
		&& gray_cnt_q < GCNT_W'(GRAY_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			fill_q     <= '{default: '0};
			head_q     <= '{default: '0};
			spread_q   <= 8'd16;
			gray_cnt_q <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				spread_q <= cfg_data;
			end
			if (cmd.exec) begin
				case (mode_q)
					MODE_REG: begin
						if (!hit_any && free_any) begin
							used_q[free_idx] <= 1'b1;
							fill_q[free_idx] <= '0;
							head_q[free_idx] <= '0;
						end
					end
					MODE_PUSH: begin
						if (push_ok) begin
							fill_q[hit_idx] <= hit_fill + CNT_W'(1);
						end
					end
					MODE_POP: begin
						if (pop_ok) begin
							fill_q[hit_idx] <= hit_fill - CNT_W'(1);
							head_q[hit_idx] <= win_wrap((WIN_W+1)'(hit_head) + (WIN_W+1)'(1));
						end
					end
					MODE_CLR: begin
						gray_cnt_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.append) begin
				gray_cnt_q <= gray_cnt_q + GCNT_W'(1);
			end
			if (cmd.emit_final || cmd.emit_grp) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= st_c;
			res_full_q   <= full_c;
			res_pop_q    <= pop_ok;
			if (mode_q == MODE_REG && !hit_any && free_any) begin
				sender_q[free_idx] <= id_q;
			end
		end
		if (cmd.append) begin
			gray_q[gray_cnt_q[GIDX_W-1:0]] <= gmask_c;
			res_mask_q <= gmask_c;
		end
		if (cmd.emit_final) begin
			status        <= res_status_q;
			popped_rssi   <= res_pop_q ? $signed(ram_rdata) : 8'sd0;
			window_full   <= res_full_q;
			group_valid   <= 1'b0;
			group_mask    <= '0;
			gray_nonempty <= gray_cnt_q != '0;
			last          <= 1'b1;
		end else if (cmd.emit_grp) begin
			status        <= ST_OK;
			popped_rssi   <= 8'sd0;
			window_full   <= 1'b0;
			group_valid   <= 1'b1;
			group_mask    <= res_mask_q;
			gray_nonempty <= 1'b0;
			last          <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* design/rwsg_ctrl.sv */
`default_nettype none
module rwsg_ctrl import rwsg_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire dp_sts_t sts,
	output ctl_cmd_t     cmd
);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_DECODE  = 12'b000000000010,
		S_EMIT    = 12'b000000000100,
		S_EV_NEXT = 12'b000000001000,
		S_SUM     = 12'b000000010000,
		S_MEAN    = 12'b000000100000,
		S_SQ      = 12'b000001000000,
		S_VAR     = 12'b000010000000,
		S_SQRT    = 12'b000100000000,
		S_KCALC   = 12'b001000000000,
		S_CMP     = 12'b010000000000,
		S_GEMIT   = 12'b100000000000
	} state_t;

	state_t            state_q, state_d;
	logic [TCNT_W-1:0] t_q, t_d;
	logic [CNT_W-1:0]  j_q, j_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		t_d     = t_q;
		j_d     = j_q;
		cmd     = '0;
		cmd.slot = t_q;
		cmd.step = j_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.exec = 1'b1;
				if (sts.mode == MODE_EVAL) begin
					t_d     = '0;
					state_d = S_EV_NEXT;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_EV_NEXT: begin
				if (t_q == TCNT_W'(MAX_SENDERS)) begin
					t_d     = '0;
					state_d = S_CMP;
				end else if (sts.test[t_q[SLOT_W-1:0]]) begin
					cmd.ev_clear = 1'b1;
					j_d          = '0;
					state_d      = S_SUM;
				end else begin
					t_d = t_q + TCNT_W'(1);
				end
			end
			S_SUM, S_SQ: begin
				cmd.rd_eval = j_q != CNT_W'(WINDOW_LEN);
				if (state_q == S_SUM) begin
					cmd.acc_sum = j_q != '0;
				end else begin
					cmd.acc_sq = j_q != '0;
				end
				if (j_q == CNT_W'(WINDOW_LEN)) begin
					j_d     = '0;
					state_d = (state_q == S_SUM) ? S_MEAN : S_VAR;
				end else begin
					j_d = j_q + CNT_W'(1);
				end
			end
			S_MEAN: begin
				cmd.mean_calc = 1'b1;
				state_d       = S_SQ;
			end
			S_VAR: begin
				cmd.var_calc = 1'b1;
				j_d          = '0;
				state_d      = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (j_q == CNT_W'(SQRT_STEPS - 1)) begin
					state_d = S_KCALC;
				end else begin
					j_d = j_q + CNT_W'(1);
				end
			end
			S_KCALC: begin
				cmd.k_calc = 1'b1;
				t_d        = t_q + TCNT_W'(1);
				state_d    = S_EV_NEXT;
			end
			S_CMP: begin
				if (t_q == TCNT_W'(MAX_SENDERS)) begin
					state_d = S_EMIT;
				end else if (sts.grp_new) begin
					cmd.append = 1'b1;
					state_d    = S_GEMIT;
				end else begin
					t_d = t_q + TCNT_W'(1);
				end
			end
			S_GEMIT: begin
				if (sts.out_free) begin
					cmd.emit_grp = 1'b1;
					t_d          = t_q + TCNT_W'(1);
					state_d      = S_CMP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			t_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			t_q     <= t_d;
			j_q     <= j_d;
		end
	end

endmodule
`default_nettype wire

/* design/rssi_window_similarity_grouper.sv */
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// in       | in_valid, in_ready, mode, sender_id,      | inbound
//          | rssi_sample                               |
// out      | out_valid, out_ready, status, popped_rssi,| outbound
//          | window_full, group_valid, group_mask,     |
//          | gray_nonempty, last                       |
// cfg      | cfg_valid, cfg_ready, cfg_data            | inbound
//
// Register, push, pop, clear: each transaction passes through accept, decode/execute and emit.
// Evaluate: per full window a sum pass over the sample RAM read port, the mean, a
//   squared-deviation pass, the variance, 8 root steps and the spread bounds; then a
//   comparison scan emits one result per new group before the final result.
// Reset (arst_n low) empties the sender table and gray list and sets spread_factor to 1.0.
// A stalled output holds the controller in its emit states; no new input is taken until
//   the last result of the current transaction is registered.
`default_nettype none
module rssi_window_similarity_grouper import rwsg_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        mode,
	input  wire logic [7:0]        sender_id,
	input  wire logic signed [7:0] rssi_sample,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        cfg_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             status,
	output logic signed [7:0]      popped_rssi,
	output logic                   window_full,
	output logic                   group_valid,
	output logic [7:0]             group_mask,
	output logic                   gray_nonempty,
	output logic                   last
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// The spread factor register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	rwsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rwsg_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.sender_id     (sender_id),
		.rssi_sample   (rssi_sample),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.popped_rssi   (popped_rssi),
		.window_full   (window_full),
		.group_valid   (group_valid),
		.group_mask    (group_mask),
		.gray_nonempty (gray_nonempty),
		.last          (last)
	);

endmodule
`default_nettype wire

/* design/rwsg_checker.sv */
`default_nettype none
module rwsg_checker import rwsg_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] status,
	input wire logic       group_valid,
	input wire logic [7:0] group_mask,
	input wire logic       last
);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(group_mask))
		else $error("stalled result changed");

	// Drop ready after an accepted transaction.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	a_group_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && group_valid |-> !last && status == ST_OK && $countones(group_mask) >= 2)
		else $error("malformed group result");

	a_error_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && !group_valid)
		else $error("error status on a non-final result");

endmodule

bind rssi_window_similarity_grouper rwsg_checker u_chk (.*);
`default_nettype wire
